// ----- rtl/tfpu_pkg.sv -----
// shared types and constants for the three-frequency phase unwrapper
package tfpu_pkg;

    // default fraction bits of one turn
    localparam int PHASE_FRAC_BITS_DEF = 16;

    // fixed field widths
    localparam int PHASE_IN_W      = 16;
    localparam int MOD_W           = 20;
    localparam int RATIO_W         = 24;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int OUT_W           = 27;

    // output saturation limits
    localparam int OUT_MAX = 67108863;
    localparam int OUT_MIN = -67108864;

    // fringe order widths (beat order and high order)
    localparam int K12_W = 10;
    localparam int K1_W  = 19;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RATIO_HIGH_TO_BEAT  = 2'd0,
        CFG_RATIO_BEAT_TO_BEAT2 = 2'd1,
        CFG_MIN_MODULATION      = 2'd2
    } tfpu_cfg_idx_t;

    localparam logic [RATIO_W-1:0] RATIO_RESET   = 24'd524288;
    localparam logic [MOD_W-1:0]   MIN_MOD_RESET = 20'd0;

    // load enables for the three stages of one fringe order unit
    typedef struct packed {
        logic mul;
        logic sub;
        logic rnd;
    } tfpu_stage_en_t;

endpackage

// ----- rtl/tfpu_in_if.sv -----
// pixel input channel: three wrapped phases and three modulations
interface tfpu_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] wrapped_high;
    logic [15:0] wrapped_mid;
    logic [15:0] wrapped_low;
    logic [19:0] mod_high;
    logic [19:0] mod_mid;
    logic [19:0] mod_low;

    modport source (
        output valid, wrapped_high, wrapped_mid, wrapped_low, mod_high, mod_mid, mod_low,
        input  ready
    );
    modport sink (
        input  valid, wrapped_high, wrapped_mid, wrapped_low, mod_high, mod_mid, mod_low,
        output ready
    );
endinterface

// ----- rtl/tfpu_out_if.sv -----
// result channel: absolute phase with valid and clip flags
interface tfpu_out_if;
    logic               valid;
    logic               ready;
    logic signed [26:0] absolute_phase;
    logic               phase_valid;
    logic               clipped;

    modport source (
        output valid, absolute_phase, phase_valid, clipped,
        input  ready
    );
    modport sink (
        input  valid, absolute_phase, phase_valid, clipped,
        output ready
    );
endinterface

// ----- rtl/tfpu_order.sv -----
// fringe order unit: multiply by ratio, subtract reference, round to whole turns
module tfpu_order #(
    parameter int FRAC_BITS = tfpu_pkg::PHASE_FRAC_BITS_DEF,
    parameter int A_W       = tfpu_pkg::PHASE_FRAC_BITS_DEF + 1,
    parameter int K_W       = tfpu_pkg::K12_W
) (
    input  logic                            clk,
    input  tfpu_pkg::tfpu_stage_en_t        en,
    input  logic signed [A_W-1:0]           a,
    input  logic [tfpu_pkg::RATIO_W-1:0]    ratio,
    input  logic [FRAC_BITS-1:0]            phase_ref,
    output logic signed [K_W-1:0]           order,
    output logic [FRAC_BITS-1:0]            phase_ref_out
);
    import tfpu_pkg::*;

    localparam int SH  = FRAC_BITS + RATIO_FRAC_BITS;
    localparam int P_W = A_W + RATIO_W + 1;
    localparam int X_W = P_W + 1;
    localparam logic signed [X_W-1:0] HALF = X_W'(1) << (SH - 1);

    logic signed [P_W-1:0]  prod_reg, prod_next;
    logic signed [X_W-1:0]  x_reg, x_next;
    logic signed [X_W-1:0]  ref_s;
    logic signed [X_W-1:0]  rnd;
    logic signed [K_W-1:0]  order_reg, order_next;
    logic [FRAC_BITS-1:0]   ph_mul_reg, ph_sub_reg, ph_rnd_reg;

    // product of phase operand and ratio
    assign prod_next = a * $signed({1'b0, ratio});

    // remove the reference phase scaled to the product's fraction
    assign ref_s  = $signed(X_W'({ph_mul_reg, {RATIO_FRAC_BITS{1'b0}}}));
    assign x_next = X_W'(prod_reg) - ref_s;

    // round half away from zero: floor((x + half - neg) / 2^SH)
    assign rnd        = x_reg + HALF - X_W'(x_reg[X_W-1]);
    assign order_next = rnd[SH +: K_W];

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en.mul)
        begin
            prod_reg   <= prod_next;
            ph_mul_reg <= phase_ref;
        end
        if (en.sub)
        begin
            x_reg      <= x_next;
            ph_sub_reg <= ph_mul_reg;
        end
        if (en.rnd)
        begin
            order_reg  <= order_next;
            ph_rnd_reg <= ph_sub_reg;
        end
    end

    assign order         = order_reg;
    assign phase_ref_out = ph_rnd_reg;

endmodule

// ----- rtl/three_freq_phase_unwrap.sv -----
// top level of the three-frequency heterodyne phase unwrapper
// Takes one pixel word per clock while pixel.ready is high and returns one result word
// per pixel through the eight-stage pipeline: beat phases and modulation gate, then
// for each of the two nested fringe orders a multiply stage, a subtract stage and a
// rounding stage, then saturation into the output register. Each stage holds its
// word only while the next one is full and stalled, so a new pixel is taken every
// cycle as long as the pipeline has a free slot. The user must write ratios and the
// modulation threshold through the configuration port only while idle; the block does not enforce it.
module three_freq_phase_unwrap #(
    parameter int PHASE_FRAC_BITS = tfpu_pkg::PHASE_FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tfpu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfpu_pkg::CFG_DATA_W-1:0] cfg_data,
    tfpu_in_if.sink                         pixel,
    tfpu_out_if.source                      result
);
    import tfpu_pkg::*;

    localparam int F      = PHASE_FRAC_BITS;
    localparam int NSTAGE = 8;
    localparam int A12_W  = F + 1;
    localparam int ABS_W  = F + K12_W;
    localparam int RES_W  = F + K1_W;
    localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(OUT_MAX);
    localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(OUT_MIN);

    // configuration registers
    logic [RATIO_W-1:0] ratio12_reg;
    logic [RATIO_W-1:0] ratio123_reg;
    logic [MOD_W-1:0]   min_mod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio12_reg  <= RATIO_RESET;
            ratio123_reg <= RATIO_RESET;
            min_mod_reg  <= MIN_MOD_RESET;
        end
        else if (cfg_we)
        begin
            case (tfpu_cfg_idx_t'(cfg_index))
                CFG_RATIO_HIGH_TO_BEAT:  ratio12_reg  <= cfg_data[RATIO_W-1:0];
                CFG_RATIO_BEAT_TO_BEAT2: ratio123_reg <= cfg_data[RATIO_W-1:0];
                CFG_MIN_MODULATION:      min_mod_reg  <= cfg_data[MOD_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valid bits and load enables
    logic [NSTAGE:1] v_reg;
    logic [NSTAGE:1] en;

    always_comb
    begin
        en[NSTAGE] = !v_reg[NSTAGE] || result.ready;
        for (int i = NSTAGE - 1; i >= 1; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                v_reg[1] <= pixel.valid;
            end
            for (int i = 2; i <= NSTAGE; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign pixel.ready = en[1];

    // stage 1: beat phases and modulation gate
    logic [F-1:0] p1, p2, p3;
    logic [F-1:0] p12_next, p23_next, p123_next;
    logic         low_mod;
    logic [F-1:0] p1_s1_reg, p12_s1_reg, p123_s1_reg;
    logic         ok_reg [1:NSTAGE-1];

    assign p1        = F'(pixel.wrapped_high);
    assign p2        = F'(pixel.wrapped_mid);
    assign p3        = F'(pixel.wrapped_low);
    assign p12_next  = p1 - p2;
    assign p23_next  = p2 - p3;
    assign p123_next = p12_next - p23_next;
    assign low_mod   = (min_mod_reg != '0) &&
                       (pixel.mod_high < min_mod_reg || pixel.mod_mid < min_mod_reg ||
                        pixel.mod_low < min_mod_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            p1_s1_reg   <= p1;
            p12_s1_reg  <= p12_next;
            p123_s1_reg <= p123_next;
        end
    end

    // gate flag travels alongside the data
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ok_reg[1] <= !low_mod;
        end
        for (int i = 2; i <= NSTAGE - 1; i++)
        begin
            if (en[i])
            begin
                ok_reg[i] <= ok_reg[i-1];
            end
        end
    end

    // high phase delayed over the beat order stages
    logic [F-1:0] p1_dly_reg [2:4];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            p1_dly_reg[2] <= p1_s1_reg;
        end
        if (en[3])
        begin
            p1_dly_reg[3] <= p1_dly_reg[2];
        end
        if (en[4])
        begin
            p1_dly_reg[4] <= p1_dly_reg[3];
        end
    end

    // stages 2 to 4: beat fringe order
    tfpu_stage_en_t         en12, en1;
    logic signed [K12_W-1:0] k12;
    logic [F-1:0]            p12_dly;

    assign en12 = '{mul: en[2], sub: en[3], rnd: en[4]};

    tfpu_order #(
        .FRAC_BITS (F),
        .A_W       (A12_W),
        .K_W       (K12_W)
    ) u_order12 (
        .clk           (clk),
        .en            (en12),
        .a             ($signed({1'b0, p123_s1_reg})),
        .ratio         (ratio123_reg),
        .phase_ref     (p12_s1_reg),
        .order         (k12),
        .phase_ref_out (p12_dly)
    );

    // absolute beat phase is order and fraction side by side
    logic signed [ABS_W-1:0] abs12;
    assign abs12 = $signed({k12, p12_dly});

    // stages 5 to 7: high fringe order
    logic signed [K1_W-1:0] k1;
    logic [F-1:0]           p1_dly;

    assign en1 = '{mul: en[5], sub: en[6], rnd: en[7]};

    tfpu_order #(
        .FRAC_BITS (F),
        .A_W       (ABS_W),
        .K_W       (K1_W)
    ) u_order1 (
        .clk           (clk),
        .en            (en1),
        .a             (abs12),
        .ratio         (ratio12_reg),
        .phase_ref     (p1_dly_reg[4]),
        .order         (k1),
        .phase_ref_out (p1_dly)
    );

    // stage 8: saturate into the output word
    logic signed [RES_W-1:0] res;
    logic signed [OUT_W-1:0] phase_reg, phase_next;
    logic                    clip_reg, clip_next;
    logic                    pv_reg;

    assign res = $signed({k1, p1_dly});

    always_comb
    begin
        phase_next = res[OUT_W-1:0];
        clip_next  = 1'b0;
        if (!ok_reg[NSTAGE-1])
        begin
            phase_next = '0;
        end
        else if (res > RES_MAX)
        begin
            phase_next = OUT_W'(OUT_MAX);
            clip_next  = 1'b1;
        end
        else if (res < RES_MIN)
        begin
            phase_next = OUT_W'(OUT_MIN);
            clip_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTAGE])
        begin
            phase_reg <= phase_next;
            clip_reg  <= clip_next;
            pv_reg    <= ok_reg[NSTAGE-1];
        end
    end

    assign result.valid          = v_reg[NSTAGE];
    assign result.absolute_phase = phase_reg;
    assign result.phase_valid    = pv_reg;
    assign result.clipped        = clip_reg;

endmodule

// ----- rtl/tfpu_checker.sv -----
// port-level checks for the phase unwrapper and the bind that attaches them
module tfpu_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_ready,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [26:0] absolute_phase,
    input  logic        phase_valid,
    input  logic        clipped
);
    import tfpu_pkg::*;

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // input is refused only when every stage is full and the output is stalled
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input refused with a free pipeline slot");

    // a rejected pixel carries a zero phase and no clip flag
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !phase_valid |-> absolute_phase == '0 && !clipped)
        else $error("rejected pixel with nonzero payload");

    // a clipped phase sits at one of the range limits
    a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |->
            (absolute_phase == OUT_W'(OUT_MAX) || absolute_phase == OUT_W'(OUT_MIN)))
        else $error("clipped phase not at a range limit");

endmodule

bind three_freq_phase_unwrap tfpu_checker u_tfpu_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (pixel.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .absolute_phase (result.absolute_phase),
    .phase_valid    (result.phase_valid),
    .clipped        (result.clipped)
);

// ----- sim/testbench.sv -----
// self-checking testbench for the three-frequency heterodyne phase unwrapper
module testbench;

    import tfpu_pkg::*;

    localparam int      HALF_PERIOD   = 5;
    localparam int      TURN_BITS     = PHASE_FRAC_BITS_DEF;
    localparam int      ORDER_SHIFT   = TURN_BITS + RATIO_FRAC_BITS;
    localparam longint  TURN          = longint'(1) << TURN_BITS;
    localparam longint  TURN_MASK     = TURN - 1;
    localparam int      PHASE_COUNT   = 8;
    localparam int      PHASE_ITEMS   = 212;
    localparam int      SETTLE_CYCLES = 40;
    localparam int      LIMIT_CYCLES  = 400000;
    localparam logic [RATIO_W-1:0] RATIO_MAX = {RATIO_W{1'b1}};
    localparam logic [MOD_W-1:0]   MOD_MAX   = {MOD_W{1'b1}};
    localparam logic [15:0]        PH_MAX    = 16'hFFFF;

    // one pixel word as it goes into the block
    typedef struct packed {
        logic [PHASE_IN_W-1:0] wrapped_high;
        logic [PHASE_IN_W-1:0] wrapped_mid;
        logic [PHASE_IN_W-1:0] wrapped_low;
        logic [MOD_W-1:0]      mod_high;
        logic [MOD_W-1:0]      mod_mid;
        logic [MOD_W-1:0]      mod_low;
    } pixel_word_t;

    // one result word as it leaves the block
    typedef struct packed {
        logic signed [OUT_W-1:0] phase;
        logic                    phase_valid;
        logic                    clipped;
    } unwrap_result_t;

    typedef enum logic [1:0] {
        ENTRY_PIXEL,
        ENTRY_CONFIG,
        ENTRY_DRAIN
    } entry_kind_t;

    typedef struct {
        entry_kind_t           kind;
        tfpu_cfg_idx_t         cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_value;
        pixel_word_t           px;
    } stim_entry_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tfpu_in_if  pixel_bus ();
    tfpu_out_if result_bus ();

    three_freq_phase_unwrap DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixel     (pixel_bus),
        .result    (result_bus)
    );

    // predictor copy of the configuration registers
    logic [RATIO_W-1:0] cfg_r12     = RATIO_RESET;
    logic [RATIO_W-1:0] cfg_r123    = RATIO_RESET;
    logic [MOD_W-1:0]   cfg_min_mod = MIN_MOD_RESET;

    stim_entry_t    stim_q[$];
    unwrap_result_t expected_results[$];
    pixel_word_t    presented;
    int             send_gap   = 0;
    bit             send_calm  = 1'b0;
    int             recv_stall = 0;
    bit             recv_calm  = 1'b0;
    int             fail_count = 0;
    int             cycle_count = 0;

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // round x / 2^ORDER_SHIFT half away from zero
    function automatic longint round_order(longint x);
        longint mag;
        longint q;
        mag = (x < 0) ? -x : x;
        q = (mag + (longint'(1) << (ORDER_SHIFT - 1))) >> ORDER_SHIFT;
        return (x < 0) ? -q : q;
    endfunction

    // heterodyne unwrap of one pixel under the current register copy
    function automatic unwrap_result_t predict_unwrap(pixel_word_t w);
        logic [MOD_W-1:0] least;
        longint p1, p2, p3, p12, p23, p123;
        longint diff, k12, abs12, k1, res;
        unwrap_result_t r;
        r = '0;
        least = w.mod_high;
        if (w.mod_mid < least)
            least = w.mod_mid;
        if (w.mod_low < least)
            least = w.mod_low;
        // modulation gate
        if (cfg_min_mod != '0 && least < cfg_min_mod)
            return r;
        p1 = longint'(w.wrapped_high) & TURN_MASK;
        p2 = longint'(w.wrapped_mid) & TURN_MASK;
        p3 = longint'(w.wrapped_low) & TURN_MASK;
        p12 = (p1 - p2) & TURN_MASK;
        p23 = (p2 - p3) & TURN_MASK;
        p123 = (p12 - p23) & TURN_MASK;
        // beat fringe order
        diff = p123 * longint'(cfg_r123) - (p12 << RATIO_FRAC_BITS);
        k12 = round_order(diff);
        abs12 = p12 + k12 * TURN;
        // high fringe order
        diff = abs12 * longint'(cfg_r12) - (p1 << RATIO_FRAC_BITS);
        k1 = round_order(diff);
        res = p1 + k1 * TURN;
        r.phase_valid = 1'b1;
        if (res > OUT_MAX)
        begin
            res = OUT_MAX;
            r.clipped = 1'b1;
        end
        if (res < OUT_MIN)
        begin
            res = OUT_MIN;
            r.clipped = 1'b1;
        end
        r.phase = res[OUT_W-1:0];
        return r;
    endfunction

    task automatic add_pixel(input logic [15:0] ph, input logic [15:0] pm,
                             input logic [15:0] pl, input logic [MOD_W-1:0] mh,
                             input logic [MOD_W-1:0] mm, input logic [MOD_W-1:0] ml);
        stim_entry_t e;
        e.kind = ENTRY_PIXEL;
        e.cfg_idx = CFG_RATIO_HIGH_TO_BEAT;
        e.cfg_value = '0;
        e.px = '{ph, pm, pl, mh, mm, ml};
        stim_q.insert(stim_q.size(), e);
    endtask

    task automatic add_entry(input entry_kind_t kind, input tfpu_cfg_idx_t idx,
                             input logic [CFG_DATA_W-1:0] value);
        stim_entry_t e;
        e.kind = kind;
        e.cfg_idx = idx;
        e.cfg_value = value;
        e.px = '0;
        stim_q.insert(stim_q.size(), e);
    endtask

    // modulation near or above the gate threshold, sometimes anywhere
    function automatic logic [MOD_W-1:0] rand_mod(logic [MOD_W-1:0] floor_mod);
        case ($urandom_range(0, 9))
            0: return MOD_W'($urandom_range(0, MOD_MAX));
            1: return floor_mod - 1'b1;
            2: return floor_mod;
            3: return MOD_MAX;
            default: return MOD_W'($urandom_range(floor_mod, MOD_MAX));
        endcase
    endfunction

    // driver: presents pixel words and performs register writes when idle
    always @(posedge clk)
    begin
        logic        next_valid;
        logic        next_we;
        stim_entry_t head;
        if (!rst_n)
        begin
            pixel_bus.valid        <= 1'b0;
            pixel_bus.wrapped_high <= '0;
            pixel_bus.wrapped_mid  <= '0;
            pixel_bus.wrapped_low  <= '0;
            pixel_bus.mod_high     <= '0;
            pixel_bus.mod_mid      <= '0;
            pixel_bus.mod_low      <= '0;
            cfg_we    <= 1'b0;
            cfg_index <= '0;
            cfg_data  <= '0;
        end
        else
        begin
            next_valid = pixel_bus.valid;
            next_we = 1'b0;
            if (pixel_bus.valid && pixel_bus.ready)
            begin
                expected_results.insert(expected_results.size(),
                                        predict_unwrap(presented));
                next_valid = 1'b0;
                if ($urandom_range(0, 47) == 0)
                    send_calm = !send_calm;
                send_gap = send_calm ? 0 : $urandom_range(0, 4);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap = send_gap - 1;
                else if (stim_q.size() != 0)
                begin
                    head = stim_q[0];
                    if (head.kind == ENTRY_PIXEL)
                    begin
                        presented = head.px;
                        pixel_bus.wrapped_high <= head.px.wrapped_high;
                        pixel_bus.wrapped_mid  <= head.px.wrapped_mid;
                        pixel_bus.wrapped_low  <= head.px.wrapped_low;
                        pixel_bus.mod_high     <= head.px.mod_high;
                        pixel_bus.mod_mid      <= head.px.mod_mid;
                        pixel_bus.mod_low      <= head.px.mod_low;
                        next_valid = 1'b1;
                        void'(stim_q.pop_front());
                    end
                    else if (expected_results.size() == 0)
                    begin
                        // pipeline empty: write a register or just release the pause
                        if (head.kind == ENTRY_CONFIG)
                        begin
                            next_we = 1'b1;
                            cfg_index <= head.cfg_idx;
                            cfg_data <= head.cfg_value;
                            case (head.cfg_idx)
                                CFG_RATIO_HIGH_TO_BEAT:  cfg_r12 = head.cfg_value[RATIO_W-1:0];
                                CFG_RATIO_BEAT_TO_BEAT2: cfg_r123 = head.cfg_value[RATIO_W-1:0];
                                CFG_MIN_MODULATION:      cfg_min_mod = head.cfg_value[MOD_W-1:0];
                                default: ;
                            endcase
                            send_gap = 2;
                        end
                        void'(stim_q.pop_front());
                    end
                end
            end
            pixel_bus.valid <= next_valid;
            cfg_we <= next_we;
        end
    end

    // monitor: random stalls on the result side, compare each word
    always @(posedge clk)
    begin
        unwrap_result_t want;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
        end
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result word: absolute_phase %0d",
                           result_bus.absolute_phase);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result_bus.absolute_phase !== want.phase)
                    begin
                        $error("absolute_phase: expected %0d, got %0d",
                               want.phase, result_bus.absolute_phase);
                        fail_count++;
                    end
                    if (result_bus.phase_valid !== want.phase_valid)
                    begin
                        $error("phase_valid: expected %0b, got %0b",
                               want.phase_valid, result_bus.phase_valid);
                        fail_count++;
                    end
                    if (result_bus.clipped !== want.clipped)
                    begin
                        $error("clipped: expected %0b, got %0b",
                               want.clipped, result_bus.clipped);
                        fail_count++;
                    end
                end
                if ($urandom_range(0, 47) == 0)
                    recv_calm = !recv_calm;
                recv_stall = recv_calm ? 0 : $urandom_range(0, 4);
            end
            else if (recv_stall > 0)
                recv_stall = recv_stall - 1;
            result_bus.ready <= (recv_stall == 0);
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int                 f_high, f_mid, f_low, beat, beat2;
        int                 jitter;
        longint             frac;
        logic [MOD_W-1:0]   floor_mod;
        logic [RATIO_W-1:0] r12, r123;
        bit                 coherent;
        logic [15:0]        ph, pm, pl;

        rst_n = 1'b0;

        // directed: phase extremes at reset ratios, gate disabled
        add_pixel(16'h0000, 16'h0000, 16'h0000, MOD_MAX, MOD_MAX, MOD_MAX);
        add_pixel(PH_MAX, PH_MAX, PH_MAX, '0, '0, '0);
        add_pixel(PH_MAX, 16'h0000, 16'h0000, 20'hAAAAA, 20'h55555, 20'hAAAAA);
        add_pixel(16'h0000, PH_MAX, 16'h0000, 20'h55555, 20'hAAAAA, 20'h55555);
        add_pixel(16'h0000, 16'h0000, PH_MAX, 20'h12345, 20'h6789A, 20'hBCDEF);
        add_pixel(16'h8000, 16'h7000, 16'h6200, 20'h01000, 20'h01000, 20'h01000);
        add_pixel(16'h5555, 16'hAAAA, 16'h5555, 20'h00010, 20'h00020, 20'h00030);
        // beat order exactly half a turn, positive then negative
        add_pixel(16'hF000, 16'hF000, 16'h0000, 20'h00400, 20'h00400, 20'h00400);
        add_pixel(16'h8000, 16'h0000, 16'h8000, 20'h00400, 20'h00400, 20'h00400);

        // directed: modulation gate, least modulation on each channel
        add_entry(ENTRY_CONFIG, CFG_MIN_MODULATION, 24'h000100);
        add_pixel(16'h1234, 16'h1111, 16'h1000, 20'h00100, 20'h00100, 20'h00100);
        add_pixel(16'h1234, 16'h1111, 16'h1000, 20'h000FF, 20'h00100, 20'h00100);
        add_pixel(16'h1234, 16'h1111, 16'h1000, 20'h00100, 20'h000FF, 20'h00100);
        add_pixel(16'h1234, 16'h1111, 16'h1000, 20'h00100, 20'h00100, 20'h000FF);
        add_pixel(16'h1234, 16'h1111, 16'h1000, '0, '0, '0);

        // directed: largest ratios, saturation high
        add_entry(ENTRY_CONFIG, CFG_RATIO_HIGH_TO_BEAT, RATIO_MAX);
        add_entry(ENTRY_CONFIG, CFG_RATIO_BEAT_TO_BEAT2, RATIO_MAX);
        add_entry(ENTRY_CONFIG, CFG_MIN_MODULATION, 24'h000000);
        add_pixel(16'h0001, 16'h0001, 16'h0000, MOD_MAX, MOD_MAX, MOD_MAX);
        add_pixel(16'h0001, 16'h8000, 16'h0000, 20'h00001, 20'h00001, 20'h00001);
        add_pixel(16'h4000, 16'h2000, 16'h1000, 20'h00001, 20'h00001, 20'h00001);
        add_pixel(PH_MAX, 16'h0000, 16'h0000, 20'h00001, 20'h00001, 20'h00001);

        // directed: zero beat ratio, most negative orders
        add_entry(ENTRY_CONFIG, CFG_RATIO_BEAT_TO_BEAT2, 24'h000000);
        add_pixel(16'h8000, 16'h0000, 16'h0000, 20'h00001, 20'h00001, 20'h00001);
        add_pixel(PH_MAX, 16'h0001, 16'h0001, 20'h00001, 20'h00001, 20'h00001);
        add_entry(ENTRY_CONFIG, CFG_RATIO_HIGH_TO_BEAT, 24'h000000);
        add_pixel(PH_MAX, 16'h8000, 16'h0000, 20'h00001, 20'h00001, 20'h00001);

        // random phases, each with its own register setting
        for (int phase_no = 0; phase_no < PHASE_COUNT; phase_no++)
        begin
            f_high = 0;
            f_mid = 0;
            f_low = 0;
            coherent = 1'b0;
            floor_mod = '0;
            if (phase_no == 0)
            begin
                r12 = RATIO_MAX;
                r123 = RATIO_MAX;
            end
            else if (phase_no == 1)
            begin
                r12 = '0;
                r123 = '0;
                floor_mod = MOD_MAX;
            end
            else if (phase_no == PHASE_COUNT - 1)
            begin
                r12 = RATIO_W'($urandom());
                r123 = RATIO_W'($urandom());
                floor_mod = MOD_W'($urandom_range(0, 16'hFFFF));
            end
            else
            begin
                // a realistic fringe set: f1 > f2 > f3 with f1-f2 > f2-f3
                beat = $urandom_range(2, 16);
                beat2 = $urandom_range(1, beat - 1);
                f_low = $urandom_range(1, 40);
                f_mid = f_low + beat2;
                f_high = f_mid + beat;
                r12 = RATIO_W'((f_high << RATIO_FRAC_BITS) / beat);
                r123 = RATIO_W'((beat << RATIO_FRAC_BITS) / (beat - beat2));
                coherent = 1'b1;
                if ($urandom_range(0, 2) != 0)
                    floor_mod = MOD_W'($urandom_range(1, 20'h003FF));
            end
            add_entry(ENTRY_CONFIG, CFG_RATIO_HIGH_TO_BEAT, r12);
            add_entry(ENTRY_CONFIG, CFG_RATIO_BEAT_TO_BEAT2, r123);
            add_entry(ENTRY_CONFIG, CFG_MIN_MODULATION,
                      {4'($urandom_range(0, 15)), floor_mod});

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2 || $urandom_range(0, 149) == 0)
                    add_entry(ENTRY_DRAIN, CFG_RATIO_HIGH_TO_BEAT, '0);
                if (coherent && $urandom_range(0, 9) < 7)
                begin
                    // phases of one true surface point, with a little noise
                    frac = longint'($urandom());
                    jitter = $urandom_range(0, 64) - 32;
                    ph = 16'(((longint'(f_high) * frac) >> 16) + jitter);
                    jitter = $urandom_range(0, 64) - 32;
                    pm = 16'(((longint'(f_mid) * frac) >> 16) + jitter);
                    jitter = $urandom_range(0, 64) - 32;
                    pl = 16'(((longint'(f_low) * frac) >> 16) + jitter);
                end
                else
                begin
                    ph = 16'($urandom_range(0, PH_MAX));
                    pm = 16'($urandom_range(0, PH_MAX));
                    pl = 16'($urandom_range(0, PH_MAX));
                end
                add_pixel(ph, pm, pl, rand_mod(floor_mod), rand_mod(floor_mod),
                          rand_mod(floor_mod));
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // wait for every word to go in and every result to come out
        while ((stim_q.size() != 0 || pixel_bus.valid || expected_results.size() != 0)
               && cycle_count < LIMIT_CYCLES)
            @(negedge clk);
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $error("timeout after %0d cycles", cycle_count);
            fail_count++;
        end
        else
            repeat (SETTLE_CYCLES) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $error("%0d result words never arrived", expected_results.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
